FILE: design/csa_pkg.sv
// Package for the configuration store allocator.
// Entry type, command codes and helpers; no dependencies.
package csa_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [16:0] REGION_RESET = 17'h01000;
    localparam logic [16:0] REGION_MAX = 17'h10000;

    localparam logic [1:0] CMD_MOVE   = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_REJECT = 2'd3;

    typedef struct packed {
        logic [23:0] key;
        logic [15:0] offset;
        logic [15:0] length;
    } entry_t;

    // Cell control, broadcast to every cell of the row.
    typedef struct packed {
        logic        shift;    // rotate the row one place toward cell 0
        logic        load;     // on a shift, a cell with is_head set takes the input entry
    } cell_ctrl_t;

    function automatic logic [16:0] pad8(input logic [15:0] len);
        logic [16:0] s;
        s = {1'b0, len} + 17'd7;
        return {s[16:3], 3'b000};
    endfunction

endpackage

FILE: design/csa_cell.sv
// One entry cell of the rotating table row.
// Depends on csa_pkg.
module csa_cell (
    input  logic            clk,
    input  csa_pkg::cell_ctrl_t ctrl,
    input  csa_pkg::entry_t prev,
    input  csa_pkg::entry_t load_data,
    input  logic            is_head,
    output csa_pkg::entry_t data
);
    import csa_pkg::*;

    entry_t data_reg;

    // Rotate from the neighbor; the head cell may instead take a new entry.
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            if (is_head && ctrl.load)
                data_reg <= load_data;
            else
                data_reg <= prev;
        end
    end

    assign data = data_reg;
endmodule

FILE: design/config_store_allocator_top.sv
// Top level of the configuration store allocator.
// Depends on csa_pkg and csa_cell.
// The first result of a request leaves once the lookup pass and the decision are
// done; compaction moves, the append and the clear follow in that order, and a result held by stall_out holds the pass.
// A new request is taken only in the idle state, after the lookup, compaction and
// update passes of the last one; stall_in is high until then.
// Reset clears entry count, write offset and sets region_size to 4096.
module config_store_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,
    input  logic        valid_in,
    output logic        stall_in,
    input  logic [7:0]  page_id,
    input  logic [7:0]  elem_id,
    input  logic [7:0]  event_kind,
    input  logic [15:0] byte_length,
    output logic        valid_out,
    input  logic        stall_out,
    output logic [1:0]  command,
    output logic [15:0] source_offset,
    output logic [15:0] target_offset,
    output logic [16:0] padded_length,
    output logic        overflow,
    output logic        last
);
    import csa_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FIND  = 3'd1;
    localparam logic [2:0] ST_DEC   = 3'd2;
    localparam logic [2:0] ST_PACK  = 3'd3;
    localparam logic [2:0] ST_APP   = 3'd4;
    localparam logic [2:0] ST_CLR   = 3'd5;
    localparam logic [2:0] ST_INS   = 3'd6;

    localparam logic [IDX_W-1:0] FULL = IDX_W'(TABLE_ENTRIES);

    // Row of cells; cell 0 is the head, cell i takes cell i+1 on a shift.
    // Live entries sit in cells 0..count-1 in key order; a full rotation of
    // count steps restores the order.
    entry_t     cells [TABLE_ENTRIES];
    entry_t     head_in;
    cell_ctrl_t ctrl;
    logic [IDX_W-1:0] rot_len;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++)
        begin : g_cell
            entry_t prev_d;
            // cell rot_len-1 closes the ring; new entries come in there through head_in
            always_comb
            begin
                if (IDX_W'(g) == rot_len - 1'b1)
                    prev_d = head_in;
                else if (g == TABLE_ENTRIES - 1)
                    prev_d = cells[0];
                else
                    prev_d = cells[(g + 1) % TABLE_ENTRIES];
            end
            csa_cell u_cell (
                .clk(clk), .ctrl(ctrl), .prev(prev_d),
                .load_data(head_in), .is_head(1'b0), .data(cells[g])
            );
        end
    endgenerate

    logic [2:0]       state_reg, state_next;
    logic [16:0]      region_reg;
    logic [IDX_W-1:0] count_reg, count_next;
    logic [16:0]      wofs_reg, wofs_next;
    logic [IDX_W-1:0] step_reg, step_next;
    logic [23:0]      key_reg;
    logic [15:0]      len_reg;
    logic             found_reg, found_next;
    logic             ins_reg, ins_next;   // new entry already placed
    logic [16:0]      packed_reg, packed_next;
    logic [15:0]      old_ofs_reg, old_ofs_next;
    logic [15:0]      old_len_reg, old_len_next;
    // Head entry leaving the ring; after an insert it re-enters behind the new entry
    entry_t           hold_reg;

    logic        out_v_reg;
    logic [1:0]  o_cmd_reg, o_cmd;
    logic [15:0] o_src_reg, o_src, o_tgt_reg, o_tgt;
    logic [16:0] o_len_reg, o_len;
    logic        o_ovf_reg, o_ovf, o_last_reg, o_last, emit;

    logic        out_free;
    logic [16:0] plen, region, el;
    logic [17:0] sum;
    entry_t      h;

    assign out_free = !out_v_reg || !stall_out;
    assign plen     = pad8(len_reg);
    assign region   = (region_reg > REGION_MAX) ? REGION_MAX : region_reg;
    assign sum      = {1'b0, wofs_reg} + {1'b0, plen};
    assign h        = cells[0];
    assign el       = pad8(h.length);
    assign stall_in = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        wofs_next    = wofs_reg;
        step_next    = step_reg;
        found_next   = found_reg;
        ins_next     = ins_reg;
        packed_next  = packed_reg;
        old_ofs_next = old_ofs_reg;
        old_len_next = old_len_reg;
        ctrl         = '0;
        head_in      = h;
        rot_len      = count_reg;
        emit   = 1'b0;
        o_cmd  = CMD_MOVE;
        o_src  = '0;
        o_tgt  = '0;
        o_len  = '0;
        o_ovf  = 1'b0;
        o_last = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                step_next  = '0;
                found_next = 1'b0;
                ins_next   = 1'b0;
                if (valid_in)
                    state_next = ST_FIND;
            end
            // full rotation; note matching entry
            ST_FIND:
            begin
                if (step_reg == count_reg)
                begin
                    state_next = ST_DEC;
                    step_next  = '0;
                end
                else
                begin
                    ctrl.shift = 1'b1;
                    step_next  = step_reg + 1'b1;
                    if (h.key == key_reg)
                    begin
                        found_next   = 1'b1;
                        old_ofs_next = h.offset;
                        old_len_next = h.length;
                    end
                end
            end
            ST_DEC:
            begin
                packed_next = '0;
                if (!found_reg && count_reg >= FULL)
                begin
                    if (out_free)
                    begin
                        emit = 1'b1; o_cmd = CMD_REJECT; o_last = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (sum > {1'b0, region})
                    state_next = ST_PACK;
                else
                    state_next = ST_APP;
            end
            // compaction, one move per entry in key order
            ST_PACK:
            begin
                if (step_reg == count_reg)
                begin
                    wofs_next  = packed_reg;
                    state_next = ST_APP;
                    step_next  = '0;
                end
                else if (out_free)
                begin
                    emit  = 1'b1;
                    o_cmd = CMD_MOVE; o_src = h.offset;
                    o_tgt = packed_reg[15:0]; o_len = el;
                    head_in = entry_t'{h.key, packed_reg[15:0], h.length};
                    ctrl.shift = 1'b1;
                    if (h.key == key_reg)
                        old_ofs_next = packed_reg[15:0];
                    packed_next = packed_reg + el;
                    step_next   = step_reg + 1'b1;
                end
            end
            ST_APP:
            begin
                if (out_free)
                begin
                    emit  = 1'b1;
                    o_cmd = CMD_APPEND; o_tgt = wofs_reg[15:0]; o_len = plen;
                    if (sum > {1'b0, region} || wofs_reg[16])
                    begin
                        o_ovf = 1'b1; o_last = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        o_last = !found_reg;
                        state_next = found_reg ? ST_CLR : ST_INS;
                        step_next  = '0;
                    end
                end
            end
            ST_CLR:
            begin
                if (out_free)
                begin
                    emit  = 1'b1;
                    o_cmd = CMD_CLEAR; o_tgt = old_ofs_reg;
                    o_len = pad8(old_len_reg); o_last = 1'b1;
                    state_next = ST_INS;
                end
            end
            // one rotation: replace the entry or insert it in key order
            ST_INS:
            begin
                rot_len = found_reg ? count_reg : count_reg + 1'b1;
                if (step_reg == rot_len)
                begin
                    count_next = rot_len;
                    wofs_next  = sum[16:0];
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctrl.shift = 1'b1;
                    step_next  = step_reg + 1'b1;
                    if (found_reg)
                    begin
                        if (h.key == key_reg)
                            head_in = entry_t'{key_reg, wofs_reg[15:0], len_reg};
                    end
                    else if (ins_reg)
                    begin
                        // entries after the new one re-enter through hold_reg;
                        // the spare slot at the end of the ring is dropped
                        head_in = hold_reg;
                    end
                    else if (step_reg == count_reg || h.key > key_reg)
                    begin
                        // place new entry; the head waits in hold_reg
                        head_in  = entry_t'{key_reg, wofs_reg[15:0], len_reg};
                        ins_next = 1'b1;
                        ctrl.load = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            region_reg <= REGION_RESET;
            count_reg  <= '0;
            wofs_reg   <= '0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            wofs_reg  <= wofs_next;
            if (cfg_we)
                region_reg <= cfg_wdata;
            if (emit)
                out_v_reg <= 1'b1;
            else if (!stall_out)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && valid_in)
        begin
            key_reg <= {page_id, elem_id, event_kind};
            len_reg <= byte_length;
        end
        step_reg    <= step_next;
        found_reg   <= found_next;
        ins_reg     <= ins_next;
        packed_reg  <= packed_next;
        old_ofs_reg <= old_ofs_next;
        old_len_reg <= old_len_next;
        if (ctrl.shift)
            hold_reg <= h;
        if (emit)
        begin
            o_cmd_reg  <= o_cmd;
            o_src_reg  <= o_src;
            o_tgt_reg  <= o_tgt;
            o_len_reg  <= o_len;
            o_ovf_reg  <= o_ovf;
            o_last_reg <= o_last;
        end
    end

    assign valid_out     = out_v_reg;
    assign command       = o_cmd_reg;
    assign source_offset = o_src_reg;
    assign target_offset = o_tgt_reg;
    assign padded_length = o_len_reg;
    assign overflow      = o_ovf_reg;
    assign last          = o_last_reg;
endmodule
